[design/assert_macros.svh]
// Assertion macros shared by the request line parser RTL.
// The plain form checks a property on every clock edge outside reset; the
// implication forms check a consequence in the same or in the next cycle.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HRLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define HRLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define HRLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HRLP_ASSERT(lbl, prop, msg)
`define HRLP_ASSERT_IMP(lbl, ante, cons, msg)
`define HRLP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[design/hrlp_pkg.sv]
package hrlp_pkg;

  // Widths fixed by the word formats.
  localparam int BYTE_W   = 8;
  localparam int LIMIT_W  = 13;
  localparam int LEN_W    = 4;
  localparam int STATUS_W = 2;
  localparam int CODE_W   = 4;
  localparam int FIELD_W  = 2;

  localparam int METHOD_BUF_LEN_DEF = 7;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd8000;
  localparam logic [LIMIT_W-1:0] COUNT_MAX   = 13'd8191;
  localparam logic [LEN_W-1:0]   LEN_MAX     = 4'd15;

  // Characters that steer the parser.
  localparam logic [BYTE_W-1:0] CHR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHR_LOW_A = 8'h61;
  localparam logic [BYTE_W-1:0] CHR_LOW_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] CASE_OFS  = 8'h20;

  // Line status codes.
  localparam logic [STATUS_W-1:0] ST_RUN        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MALFORMED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_METHOD = 2'd3;

  // Parser field codes.
  localparam logic [FIELD_W-1:0] FLD_METHOD   = 2'd0;
  localparam logic [FIELD_W-1:0] FLD_LOCATION = 2'd1;
  localparam logic [FIELD_W-1:0] FLD_VERSION  = 2'd2;

  // Method table. Names are stored left-aligned and padded with zero.
  localparam int NUM_METHODS = 9;
  localparam int MAX_NAME    = 7;

  localparam logic [CODE_W-1:0] M_GET     = 4'd0;
  localparam logic [CODE_W-1:0] M_CONNECT = 4'd8;

  localparam logic [LEN_W-1:0] METHOD_SIZE [NUM_METHODS] = '{
    4'd3, 4'd4, 4'd3, 4'd6, 4'd5, 4'd4, 4'd7, 4'd5, 4'd7
  };

  localparam logic [BYTE_W-1:0] METHOD_CHR [NUM_METHODS][MAX_NAME] = '{
    '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00},
    '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", "E", "T", "E", 8'h00},
    '{"P", "A", "T", "C", "H", 8'h00, 8'h00},
    '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00},
    '{"O", "P", "T", "I", "O", "N", "S"},
    '{"T", "R", "A", "C", "E", 8'h00, 8'h00},
    '{"C", "O", "N", "N", "E", "C", "T"}
  };

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              first_byte;
    logic              last_byte;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                method_valid;
    logic [CODE_W-1:0]   method_code;
    logic                data_valid;
    logic                field_id;
    logic [BYTE_W-1:0]   data_byte;
    logic                field_end;
  } out_word_t;

  // A received byte after classification by the front end.
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic [BYTE_W-1:0] up_byte;
    logic              first_byte;
    logic              last_byte;
    logic              is_space;
    logic              is_lf;
    logic              is_cr;
  } cls_word_t;

  // Queue handshake toward the back end.
  typedef struct packed {
    logic      valid;
    cls_word_t word;
  } queue_head_t;

endpackage

[design/http_request_line_parser_top.sv]
// HTTP request line parser. Feed the bytes of a request line one word per
// cycle, with first_byte set on the first byte of every line and last_byte on
// the last byte of the received data; every input word yields exactly one
// result word. The result reports the line status (in progress, complete,
// malformed, invalid method), flags the word on which the method was
// recognized together with its code, streams each location byte as it
// arrives and each version byte one word late, and marks the end of each
// field. A CR directly before the terminating LF is dropped. The block
// sustains one word per cycle while the queue has room: a classifying front
// end drops bytes into a two-entry queue, and the parser behind it handles one
// byte per cycle into an output register when not stalled, so a stalled result
// does not stop the next word from being accepted. A word is registered in the
// queue, then in the output register. The line limit register bounds the bytes
// examined per line; write it only while the block is idle.

`include "assert_macros.svh"

module http_request_line_parser_top #(
  parameter int METHOD_BUF_LEN = hrlp_pkg::METHOD_BUF_LEN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hrlp_pkg::LIMIT_W-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  input  hrlp_pkg::in_word_t            in_word_i,
  output logic                          in_stall_o,
  output logic                          out_valid_o,
  output hrlp_pkg::out_word_t           out_word_o,
  input  logic                          out_stall_i
);
  import hrlp_pkg::*;

  // Classified bytes wait here until the parser can take them.
  queue_head_t head;
  logic        pop;

  hrlp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_stall_o (in_stall_o),
    .head_o     (head),
    .pop_i      (pop)
  );

  // The parser owns the line state, the method buffer and the output register.
  hrlp_back #(
    .METHOD_BUF_LEN (METHOD_BUF_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

  // A word can only leave the queue when one is there.
  `HRLP_ASSERT_IMP(a_pop_has_word, pop, head.valid, "parser took a word from an empty queue")
  // A stalled result blocks the parser from overwriting it.
  `HRLP_ASSERT_IMP(a_no_overwrite, out_valid_o && out_stall_i, !pop,
    "parser advanced over a stalled result")
  // With space at the output, a waiting word is always taken.
  `HRLP_ASSERT_IMP(a_drain, head.valid && !(out_valid_o && out_stall_i), pop,
    "parser idle while a word waits")

endmodule

[design/hrlp_front.sv]
`include "assert_macros.svh"

module hrlp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  hrlp_pkg::in_word_t  in_word_i,
  output logic                in_stall_o,
  output hrlp_pkg::queue_head_t head_o,
  input  logic                pop_i
);
  import hrlp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  cls_word_t        entry_q [QUEUE_DEPTH];
  cls_word_t        cls;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;

  // Classify the byte on the way in so the parser sees ready-made flags.
  always_comb begin
    cls.in_byte    = in_word_i.in_byte;
    cls.first_byte = in_word_i.first_byte;
    cls.last_byte  = in_word_i.last_byte;
    cls.is_space   = (in_word_i.in_byte == CHR_SPACE);
    cls.is_lf      = (in_word_i.in_byte == CHR_LF);
    cls.is_cr      = (in_word_i.in_byte == CHR_CR);
    if ((in_word_i.in_byte >= CHR_LOW_A) && (in_word_i.in_byte <= CHR_LOW_Z)) begin
      cls.up_byte = in_word_i.in_byte - CASE_OFS;
    end else begin
      cls.up_byte = in_word_i.in_byte;
    end
  end

  assign in_stall_o = (count_q == CNT_FULL);
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push && pop_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.word  = entry_q[rd_ptr_q];

  `HRLP_ASSERT(a_count_bound, count_q <= CNT_FULL, "queue count above depth")
  `HRLP_ASSERT_IMP(a_pop_nonempty, pop_i, count_q != '0, "pop from empty queue")
  `HRLP_ASSERT_NEXT(a_push_grows, push && !pop_i, count_q == $past(count_q) + CNT_W'(1),
    "queue count did not grow on push")

endmodule

[design/hrlp_back.sv]
`include "assert_macros.svh"

module hrlp_back #(
  parameter int METHOD_BUF_LEN = hrlp_pkg::METHOD_BUF_LEN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hrlp_pkg::LIMIT_W-1:0]  cfg_data_i,
  input  hrlp_pkg::queue_head_t         head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  output hrlp_pkg::out_word_t           out_word_o,
  input  logic                          out_stall_i
);
  import hrlp_pkg::*;

  localparam int IDX_W = $clog2(METHOD_BUF_LEN);

  logic [BYTE_W-1:0]   buf_q [METHOD_BUF_LEN];
  logic [LIMIT_W-1:0]  limit_q;
  logic [FIELD_W-1:0]  field_q, field_d, field_e;
  logic [LEN_W-1:0]    len_q, len_d, len_e;
  logic [LIMIT_W-1:0]  cnt_q, cnt_d, cnt_e;
  logic [BYTE_W-1:0]   held_q, held_d, held_e;
  logic                held_vld_q, held_vld_d, held_vld_e;
  logic [STATUS_W-1:0] fstat_q, fstat_d, fstat_e;
  logic                out_valid_q;
  out_word_t           out_q, res;
  logic                buf_we;
  logic [NUM_METHODS-1:0] hit;
  logic                hit_any;
  logic [CODE_W-1:0]   hit_code;
  cls_word_t           w;

  assign w     = head_i.word;
  assign pop_o = head_i.valid && (!out_valid_q || !out_stall_i);

  // Start of a new line clears the parser state before the byte is used.
  always_comb begin
    if (w.first_byte) begin
      field_e    = FLD_METHOD;
      len_e      = '0;
      cnt_e      = '0;
      held_e     = '0;
      held_vld_e = 1'b0;
      fstat_e    = ST_RUN;
    end else begin
      field_e    = field_q;
      len_e      = len_q;
      cnt_e      = cnt_q;
      held_e     = held_q;
      held_vld_e = held_vld_q;
      fstat_e    = fstat_q;
    end
  end

  // Compare the buffered method against every name in parallel.
  always_comb begin
    hit_code = M_GET;
    for (int m = 0; m < NUM_METHODS; m++) begin
      hit[m] = (len_e == METHOD_SIZE[m]);
      for (int k = 0; k < MAX_NAME; k++) begin
        if ((LEN_W'(k) < METHOD_SIZE[m]) && (buf_q[k] != METHOD_CHR[m][k])) begin
          hit[m] = 1'b0;
        end
      end
    end
    for (int m = NUM_METHODS - 1; m >= 0; m--) begin
      if (hit[m]) begin
        hit_code = CODE_W'(m);
      end
    end
  end

  assign hit_any = |hit;

  always_comb begin
    field_d    = field_e;
    len_d      = len_e;
    cnt_d      = cnt_e;
    held_d     = held_e;
    held_vld_d = held_vld_e;
    fstat_d    = fstat_e;
    buf_we     = 1'b0;
    res        = '0;
    if (fstat_e != ST_RUN) begin
      res.status = fstat_e;
    end else begin
      cnt_d = (cnt_e != COUNT_MAX) ? cnt_e + LIMIT_W'(1) : cnt_e;
      unique case (field_e)
        FLD_METHOD: begin
          if (w.is_space) begin
            if (hit_any) begin
              res.method_valid = 1'b1;
              res.method_code  = hit_code;
              field_d          = FLD_LOCATION;
            end else begin
              fstat_d = ST_BAD_METHOD;
            end
          end else begin
            buf_we = (32'(len_e) < METHOD_BUF_LEN);
            if (len_e != LEN_MAX) begin
              len_d = len_e + LEN_W'(1);
            end
          end
        end
        FLD_LOCATION: begin
          if (w.is_space) begin
            res.field_end = 1'b1;
            field_d       = FLD_VERSION;
          end else begin
            res.data_valid = 1'b1;
            res.data_byte  = w.in_byte;
          end
        end
        default: begin
          // Version bytes lag by one so a CR right before the LF is dropped.
          if (w.is_lf) begin
            res.field_end = 1'b1;
            if (held_vld_e && (held_e != CHR_CR)) begin
              res.data_valid = 1'b1;
              res.data_byte  = held_e;
            end
            held_vld_d = 1'b0;
            held_d     = '0;
            fstat_d    = ST_DONE;
          end else begin
            if (held_vld_e) begin
              res.data_valid = 1'b1;
              res.data_byte  = held_e;
            end
            held_d     = w.in_byte;
            held_vld_d = 1'b1;
          end
          res.field_id = res.data_valid || res.field_end;
        end
      endcase
      if ((fstat_d == ST_RUN) && (w.last_byte || (cnt_d >= limit_q))) begin
        fstat_d    = ST_MALFORMED;
        held_vld_d = 1'b0;
        held_d     = '0;
      end
      res.status = fstat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RESET;
      field_q     <= FLD_METHOD;
      len_q       <= '0;
      cnt_q       <= '0;
      held_q      <= '0;
      held_vld_q  <= 1'b0;
      fstat_q     <= ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (pop_o) begin
        field_q    <= field_d;
        len_q      <= len_d;
        cnt_q      <= cnt_d;
        held_q     <= held_d;
        held_vld_q <= held_vld_d;
        fstat_q    <= fstat_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
    if (pop_o && buf_we) begin
      buf_q[len_e[IDX_W-1:0]] <= w.up_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `HRLP_ASSERT_IMP(a_method_code, out_valid_q && out_q.method_valid,
    out_q.method_code <= M_CONNECT, "method reported with a bad code")
  `HRLP_ASSERT_IMP(a_one_kind, out_valid_q && out_q.method_valid,
    !out_q.data_valid && !out_q.field_end, "method word also carries field data")
  `HRLP_ASSERT_IMP(a_held_in_version, held_vld_q, field_q == FLD_VERSION,
    "held byte outside the version field")

endmodule
